// File: hdl/itt_pkg.sv
// Shared types, codes and helpers for the interval task timer table.
`default_nettype none

package itt_pkg;

	localparam int MODE_W = 3;
	localparam int IDX_W  = 4;
	localparam int TIME_W = 32;
	localparam int KIND_W = 2;

	localparam logic [MODE_W-1:0] MODE_CONFIGURE = 3'd0;
	localparam logic [MODE_W-1:0] MODE_START     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_STOP      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_UPDATE    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SERVICE   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_QUERY     = 3'd5;

	localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACK    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NEXT   = 2'd2;

	typedef enum logic [1:0] {
		ST_UNINIT  = 2'd0,
		ST_STOPPED = 2'd1,
		ST_ACTIVE  = 2'd2
	} slot_st_t;

	// One stored slot: repeat flag, interval and start time.
	typedef struct packed {
		logic              rep;
		logic [TIME_W-1:0] ivl;
		logic [TIME_W-1:0] start;
	} slot_word_t;

	typedef struct packed {
		logic load_item;   // capture the input item
		logic clear_best;  // restart the least-remaining search
		logic rd_en;       // read one slot word
		logic rd_walk;     // read address from the walk counter, else the item slot
		logic emit_final;  // present the next-due item
	} ctrl_cmd_t;

	typedef struct packed {
		logic walk_last;   // walk counter sits on the last slot
	} ctrl_stat_t;

	// A zero request for a repeating task becomes 1; a request above the limit clamps to the limit.
	function automatic logic [TIME_W-1:0] clamp_interval(
		input logic              rep,
		input logic [TIME_W-1:0] iv,
		input logic [TIME_W-1:0] max_iv
	);
		logic [TIME_W-1:0] res;
		if (rep && (iv == '0)) begin
			res = TIME_W'(1);
		end else if (iv > max_iv) begin
			res = max_iv;
		end else begin
			res = iv;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: hdl/itt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module itt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/itt_ctrl.sv
// Sequencer for the timer table: accepts items, walks slots, drains the pipeline.
`default_nettype none

module itt_ctrl
	import itt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MODE_W-1:0] mode,
	input  wire ctrl_stat_t        stat,
	output ctrl_cmd_t              cmd,
	output logic                   busy
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_ISSUE,
		S_FLUSH1,
		S_FLUSH2,
		S_FINAL
	} state_t;

	state_t state_q;
	logic   svc_q;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = (state_q == S_IDLE) && start;

	always_comb begin
		cmd            = '0;
		cmd.load_item  = accept;
		cmd.clear_best = accept && (mode == MODE_SERVICE);
		cmd.rd_en      = (state_q == S_WALK) || (state_q == S_ISSUE);
		cmd.rd_walk    = (state_q == S_WALK);
		cmd.emit_final = (state_q == S_FINAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			svc_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						svc_q   <= (mode == MODE_SERVICE);
						state_q <= (mode == MODE_SERVICE) ? S_WALK : S_ISSUE;
					end
				end
				S_WALK: begin
					if (stat.walk_last) begin
						state_q <= S_FLUSH1;
					end
				end
				S_ISSUE:  state_q <= S_FLUSH1;
				S_FLUSH1: state_q <= S_FLUSH2;
				S_FLUSH2: state_q <= svc_q ? S_FINAL : S_IDLE;
				S_FINAL:  state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/itt_datapath.sv
// Slot storage, elapsed/remaining arithmetic, slot updates and result register.
`default_nettype none

module itt_datapath
	import itt_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_cmd_t         cmd,
	output ctrl_stat_t             stat,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [IDX_W-1:0]  task_index,
	input  wire logic [TIME_W-1:0] interval,
	input  wire logic              repeat_flag,
	input  wire logic [TIME_W-1:0] now_ms,
	input  wire logic              cfg_we,
	input  wire logic [TIME_W-1:0] cfg_data,
	output logic                   result_strobe,
	output logic [KIND_W-1:0]      kind,
	output logic [IDX_W-1:0]       slot,
	output logic                   ok,
	output logic [TIME_W-1:0]      remaining_ms,
	output logic [TIME_W-1:0]      age_ms,
	output logic                   last
);
	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int WORD_W = $bits(slot_word_t);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

	// Configuration and captured item
	logic [TIME_W-1:0] max_q;
	logic [MODE_W-1:0] mode_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0] iv_q;
	logic              rep_q;
	logic [TIME_W-1:0] now_q;
	logic              in_range_q;

	logic [SLOT_W-1:0] walk_cnt_q;
	logic [SLOT_W-1:0] rd_addr;

	// Stage 1: read data returns
	logic              v_s1;
	logic              cmd_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [WORD_W-1:0] rd_data;
	slot_word_t        rd_word;

	// Stage 2: decide and write back
	logic              v_s2;
	logic              cmd_s2;
	logic [SLOT_W-1:0] slot_s2;
	slot_word_t        word_s2;
	logic [TIME_W-1:0] el_s2;
	slot_st_t          st_s2;

	slot_st_t          st_q [NUM_SLOTS];

	logic [TIME_W-1:0] best_q;
	logic              found_q;

	logic [TIME_W-1:0] rem_s2;
	logic              ram_we;
	slot_word_t        wr_word;
	logic              st_we;
	slot_st_t          st_new;
	logic              best_upd;
	logic [TIME_W-1:0] best_new;
	logic              emit;
	logic [KIND_W-1:0] e_kind;
	logic [IDX_W-1:0]  e_slot;
	logic              e_ok;
	logic [TIME_W-1:0] e_rem;
	logic [TIME_W-1:0] e_el;
	logic              e_last;

	assign stat.walk_last = (walk_cnt_q == LAST_SLOT);
	assign rd_addr        = cmd.rd_walk ? walk_cnt_q : SLOT_W'(idx_q);
	assign rd_word        = slot_word_t'(rd_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '1;
		end else if (cfg_we) begin
			max_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q     <= mode;
			idx_q      <= task_index;
			iv_q       <= interval;
			rep_q      <= repeat_flag;
			now_q      <= now_ms;
			in_range_q <= (int'(task_index) < NUM_SLOTS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_cnt_q <= '0;
		end else if (cmd.load_item) begin
			walk_cnt_q <= '0;
		end else if (cmd.rd_en && cmd.rd_walk && !stat.walk_last) begin
			walk_cnt_q <= walk_cnt_q + SLOT_W'(1);
		end
	end

	itt_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_s2),
		.wdata (WORD_W'(wr_word)),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= !cmd.rd_walk;
		slot_s1 <= rd_addr;
		cmd_s2  <= cmd_s1;
		slot_s2 <= slot_s1;
		word_s2 <= rd_word;
		el_s2   <= now_q - rd_word.start;
		st_s2   <= st_q[slot_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				st_q[i] <= ST_UNINIT;
			end
		end else if (st_we) begin
			st_q[slot_s2] <= st_new;
		end
	end

	assign rem_s2 = (word_s2.ivl > el_s2) ? (word_s2.ivl - el_s2) : '0;

	always_comb begin
		ram_we   = 1'b0;
		wr_word  = word_s2;
		st_we    = 1'b0;
		st_new   = st_s2;
		best_upd = 1'b0;
		best_new = rem_s2;
		emit     = 1'b0;
		e_kind   = KIND_ACK;
		e_slot   = idx_q;
		e_ok     = 1'b0;
		e_rem    = '0;
		e_el     = '0;
		e_last   = 1'b1;
		if (v_s2 && !cmd_s2) begin
			if (st_s2 == ST_ACTIVE) begin
				if (rem_s2 == '0) begin
					emit   = 1'b1;
					e_kind = KIND_EXPIRY;
					e_slot = IDX_W'(slot_s2);
					e_ok   = 1'b1;
					e_el   = el_s2;
					e_last = 1'b0;
					if (word_s2.rep) begin
						// restart: remaining from now is the full interval
						ram_we        = 1'b1;
						wr_word.start = now_q;
						best_new      = word_s2.ivl;
						best_upd      = (word_s2.ivl < best_q);
					end else begin
						st_we  = 1'b1;
						st_new = ST_STOPPED;
					end
				end else begin
					best_upd = (rem_s2 < best_q);
				end
			end
		end else if (v_s2 && cmd_s2) begin
			emit = 1'b1;
			if (in_range_q) begin
				case (mode_q)
					MODE_CONFIGURE: begin
						if (st_s2 == ST_UNINIT || st_s2 == ST_STOPPED) begin
							ram_we      = 1'b1;
							wr_word.rep = rep_q;
							wr_word.ivl = clamp_interval(rep_q, iv_q, max_q);
							st_we       = 1'b1;
							st_new      = ST_STOPPED;
							e_ok        = 1'b1;
						end
					end
					MODE_START: begin
						if (st_s2 != ST_UNINIT) begin
							ram_we        = 1'b1;
							wr_word.start = now_q;
							st_we         = 1'b1;
							st_new        = ST_ACTIVE;
							e_ok          = 1'b1;
						end
					end
					MODE_STOP: begin
						if (st_s2 != ST_UNINIT) begin
							e_ok = 1'b1;
							if (st_s2 == ST_ACTIVE) begin
								st_we  = 1'b1;
								st_new = ST_STOPPED;
							end
						end
					end
					MODE_UPDATE: begin
						ram_we      = 1'b1;
						wr_word.ivl = clamp_interval(word_s2.rep, iv_q, max_q);
						if (st_s2 != ST_UNINIT) begin
							wr_word.start = now_q;
							st_we         = 1'b1;
							st_new        = ST_ACTIVE;
							e_ok          = 1'b1;
						end
					end
					MODE_QUERY: begin
						e_ok = 1'b1;
						if (st_s2 == ST_ACTIVE) begin
							e_rem = rem_s2;
							e_el  = el_s2;
						end else begin
							e_rem = max_q;
						end
					end
					default: begin
						e_ok = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_best) begin
			best_q  <= '1;
			found_q <= 1'b0;
		end else if (best_upd) begin
			best_q  <= best_new;
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= emit || cmd.emit_final;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_final) begin
			kind         <= KIND_NEXT;
			slot         <= '0;
			ok           <= 1'b1;
			remaining_ms <= found_q ? best_q : max_q;
			age_ms       <= '0;
			last         <= 1'b1;
		end else if (emit) begin
			kind         <= e_kind;
			slot         <= e_slot;
			ok           <= e_ok;
			remaining_ms <= e_rem;
			age_ms       <= e_el;
			last         <= e_last;
		end
	end

`ifndef SYNTHESIS
	a_final_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_final |-> !v_s2 && !v_s1)
		else $error("next-due item overlaps a slot still in flight");
	a_cmd_alone: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && cmd_s2 |-> !v_s1)
		else $error("command item shares the pipeline");
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we || st_we) |-> v_s2)
		else $error("slot write without a valid stage 2");
	a_last_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (kind == KIND_EXPIRY) |-> !last)
		else $error("expiry event marked as last");
`endif

endmodule

`default_nettype wire

// File: hdl/interval_task_timer_table_core.sv
// Top level of the interval task timer table.
//
// Items enter on start while busy is low; mode selects configure, start,
// stop, update, service or query for slot task_index at time now_ms.
// Results leave one per cycle, each marked by a one-cycle result_strobe;
// last marks the final result of an item. The receiver cannot hold them off.
// A command or query gives one result, through the ISSUE, FLUSH1 and FLUSH2
// states; busy stays high until that result shows.
// Service walks every slot through the slot RAM read port, one slot a
// cycle: expiry events follow in index order, then the next-due item
// after the FLUSH1, FLUSH2 and FINAL states; busy stays high until it shows.
// A new item may transfer in the cycle its predecessor's last result shows.
// max_interval is written over cfg_valid/cfg_ready/cfg_data; cfg_ready is
// high whenever busy is low.
// Reset makes every slot uninitialized and sets max_interval to all ones;
// slot words hold nothing meaningful until configured.
`default_nettype none

module interval_task_timer_table_core
	import itt_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [IDX_W-1:0]  task_index,
	input  wire logic [TIME_W-1:0] interval,
	input  wire logic              repeat_flag,
	input  wire logic [TIME_W-1:0] now_ms,
	output logic                   result_strobe,
	output logic [KIND_W-1:0]      kind,
	output logic [IDX_W-1:0]       slot,
	output logic                   ok,
	output logic [TIME_W-1:0]      remaining_ms,
	output logic [TIME_W-1:0]      age_ms,
	output logic                   last,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [TIME_W-1:0] cfg_data
);
	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	assign cfg_ready = !busy;

	itt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	itt_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (mode),
		.task_index    (task_index),
		.interval      (interval),
		.repeat_flag   (repeat_flag),
		.now_ms        (now_ms),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.kind          (kind),
		.slot          (slot),
		.ok            (ok),
		.remaining_ms  (remaining_ms),
		.age_ms        (age_ms),
		.last          (last)
	);

endmodule

`default_nettype wire
